// ===== design/bpa_pkg.sv =====
// ----------------------------------------------------------------------------
// bpa_pkg: shared types and helpers for the buddy page allocator
// Holds tree geometry, node flag codes, status codes, the request and
// response structs, the controller states and the node index helpers.
// ----------------------------------------------------------------------------
package bpa_pkg;

	localparam int TREE_LEVELS = 10;
	localparam int MAX_PAGES   = 512;
	localparam int PAGE_BYTES  = 4096;

	localparam int NODE_COUNT = (1 << TREE_LEVELS) - 1;
	localparam int NAW        = TREE_LEVELS;
	localparam int LW         = $clog2(TREE_LEVELS);
	localparam int IW         = TREE_LEVELS - 1;
	localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
	localparam int SHW        = 6;
	localparam int PAGE_W     = 10;

	localparam logic [2:0] FLAG_VALID = 3'b001;
	localparam logic [2:0] FLAG_SPLIT = 3'b010;
	localparam logic [2:0] FLAG_ALLOC = 3'b100;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_BAD_SIZE = 3'd1,
		ST_NO_MEM   = 3'd2,
		ST_BAD_ADDR = 3'd3,
		ST_BUDDY    = 3'd4
	} status_t;

	typedef enum logic {
		FUNC_ALLOC = 1'b0,
		FUNC_FREE  = 1'b1
	} func_t;

	typedef struct packed {
		logic              func;
		logic [PAGE_W-1:0] page_count;
		logic [31:0]       free_address;
	} req_t;

	typedef struct packed {
		logic [31:0] block_address;
		logic [2:0]  status;
	} rsp_t;

	typedef struct packed {
		logic          bad;
		logic [LW-1:0] lvl;
	} tgt_t;

	typedef enum logic [3:0] {
		S_CLR,
		S_IDLE,
		S_SCAN,
		S_SPL_N,
		S_SPL_R,
		S_ALC,
		S_F_RD,
		S_F_CK,
		S_F_RB,
		S_F_CB,
		S_M_W,
		S_M_RB,
		S_M_CB,
		S_M_ZM
	} state_t;

	function automatic logic [NAW-1:0] node_at(input logic [LW-1:0] lvl,
		input logic [IW-1:0] idx);
		logic [31:0] n;
		n = ((32'd1 << lvl) - 32'd1) + 32'(idx);
		return n[NAW-1:0];
	endfunction

	function automatic tgt_t target_level(input logic [PAGE_W-1:0] pages);
		tgt_t r;
		int   lg;
		lg = 0;
		for (int k = 0; k < PAGE_W + 1; k++) begin
			if ((33'd1 << k) < 33'(pages))
				lg = k + 1;
		end
		r.bad = (pages == '0) || (32'(pages) > MAX_PAGES) || (lg > TREE_LEVELS - 1);
		r.lvl = r.bad ? '0 : LW'(TREE_LEVELS - 1 - lg);
		return r;
	endfunction

endpackage

// ===== design/buddy_page_allocator.sv =====
// ----------------------------------------------------------------------------
// buddy_page_allocator: binary buddy page allocator
// Allocate: scan from the target level to the root for a free node, then
// split down to it; out of memory if none is found. A bad size or free
// address range is answered from idle. Free: check the node and its buddy,
// then merge upward while the buddy is free. One item at a time through
// the node RAM's single port while busy is high; done is registered.
// Reset clears every node with busy high. The receiver cannot stall.
// ----------------------------------------------------------------------------
module buddy_page_allocator
	import bpa_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  req_t        req,
	output logic        done,
	output rsp_t        rsp,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data
);

	state_t          state_q, state_d;
	logic [31:0]     ram_base_q;
	logic [LW-1:0]   lvl_q, tgt_q, iss_lvl_q, plvl_s1;
	logic [IW-1:0]   idx_q, iss_idx_q, pidx_s1;
	logic [SHW-1:0]  sh_q;
	logic            iss_en_q, pend_s1, plast_s1;
	logic [NAW-1:0]  clr_q;
	logic            done_q;
	rsp_t            rsp_q;

	logic            ram_en, ram_we;
	logic [NAW-1:0]  ram_addr;
	logic [2:0]      ram_wdata, rdata;
	logic            fin;
	status_t         fin_status;
	logic [31:0]     fin_addr;

	tgt_t            tl;
	logic [SHW-1:0]  sh_d;
	logic [31:0]     off, q;
	logic            oor;
	logic            found, iss_last;
	logic [LW-1:0]   lvl_inc;

	bpa_node_ram u_ram (
		.clk   (clk),
		.en    (ram_en),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (rdata)
	);

	assign tl       = target_level(req.page_count);
	assign sh_d     = SHW'(PAGE_SHIFT) + SHW'(TREE_LEVELS - 1) - SHW'(tl.lvl);
	assign off      = req.free_address - ram_base_q;
	assign q        = off >> sh_d;
	assign oor      = (q >> tl.lvl) != 32'd0;
	assign found    = pend_s1 && ((rdata & (FLAG_VALID | FLAG_SPLIT | FLAG_ALLOC))
		== FLAG_VALID);
	assign iss_last = iss_idx_q == IW'((32'd1 << iss_lvl_q) - 32'd1);
	assign lvl_inc  = lvl_q + LW'(1);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLR: begin
				if (clr_q == NAW'(NODE_COUNT - 1))
					state_d = S_IDLE;
			end
			S_IDLE: begin
				if (start) begin
					if (tl.bad)
						state_d = S_IDLE;
					else if (req.func == FUNC_ALLOC)
						state_d = S_SCAN;
					else if (!oor)
						state_d = S_F_RD;
				end
			end
			S_SCAN: begin
				if (found)
					state_d = (plvl_s1 == tgt_q) ? S_ALC : S_SPL_N;
				else if (pend_s1 && plast_s1)
					state_d = S_IDLE;
			end
			S_SPL_N: state_d = S_SPL_R;
			S_SPL_R: state_d = (lvl_inc == tgt_q) ? S_ALC : S_SPL_N;
			S_ALC:   state_d = S_IDLE;
			S_F_RD:  state_d = S_F_CK;
			S_F_CK: begin
				if ((rdata & FLAG_SPLIT) != '0 || (rdata & FLAG_VALID) == '0)
					state_d = S_IDLE;
				else if (lvl_q == '0)
					state_d = S_M_W;
				else
					state_d = S_F_RB;
			end
			S_F_RB: state_d = S_F_CB;
			S_F_CB: state_d = ((rdata & FLAG_VALID) == '0) ? S_IDLE : S_M_W;
			S_M_W:  state_d = (lvl_q == '0) ? S_IDLE : S_M_RB;
			S_M_RB: state_d = S_M_CB;
			S_M_CB: begin
				if ((rdata & (FLAG_SPLIT | FLAG_ALLOC)) == '0)
					state_d = S_M_ZM;
				else
					state_d = S_IDLE;
			end
			S_M_ZM: state_d = S_M_W;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		ram_en     = 1'b0;
		ram_we     = 1'b0;
		ram_addr   = node_at(lvl_q, idx_q);
		ram_wdata  = '0;
		fin        = 1'b0;
		fin_status = ST_OK;
		fin_addr   = '0;
		case (state_q)
			S_CLR: begin
				ram_en    = 1'b1;
				ram_we    = 1'b1;
				ram_addr  = clr_q;
				ram_wdata = (clr_q == '0) ? FLAG_VALID : 3'b000;
			end
			S_IDLE: begin
				if (start) begin
					if (tl.bad) begin
						fin        = 1'b1;
						fin_status = ST_BAD_SIZE;
					end else if (req.func == FUNC_FREE && oor) begin
						fin        = 1'b1;
						fin_status = ST_BAD_ADDR;
					end
				end
			end
			S_SCAN: begin
				ram_en   = iss_en_q && !found;
				ram_addr = node_at(iss_lvl_q, iss_idx_q);
				if (!found && pend_s1 && plast_s1) begin
					fin        = 1'b1;
					fin_status = ST_NO_MEM;
				end
			end
			S_SPL_N: begin
				ram_en    = 1'b1;
				ram_we    = 1'b1;
				ram_wdata = FLAG_SPLIT | FLAG_VALID;
			end
			S_SPL_R: begin
				ram_en    = 1'b1;
				ram_we    = 1'b1;
				ram_addr  = node_at(lvl_inc, {idx_q[IW-2:0], 1'b1});
				ram_wdata = FLAG_VALID;
			end
			S_ALC: begin
				ram_en    = 1'b1;
				ram_we    = 1'b1;
				ram_wdata = FLAG_ALLOC | FLAG_VALID;
				fin       = 1'b1;
				fin_addr  = ram_base_q + (32'(idx_q) << sh_q);
			end
			S_F_RD: ram_en = 1'b1;
			S_F_CK: begin
				if ((rdata & FLAG_SPLIT) != '0 || (rdata & FLAG_VALID) == '0) begin
					fin        = 1'b1;
					fin_status = ST_BAD_ADDR;
				end
			end
			S_F_RB, S_M_RB: begin
				ram_en   = 1'b1;
				ram_addr = node_at(lvl_q, idx_q ^ IW'(1));
			end
			S_F_CB: begin
				if ((rdata & FLAG_VALID) == '0) begin
					fin        = 1'b1;
					fin_status = ST_BUDDY;
				end
			end
			S_M_W: begin
				ram_en    = 1'b1;
				ram_we    = 1'b1;
				ram_wdata = FLAG_VALID;
				fin       = (lvl_q == '0);
			end
			S_M_CB: begin
				if ((rdata & (FLAG_SPLIT | FLAG_ALLOC)) == '0) begin
					ram_en   = 1'b1;
					ram_we   = 1'b1;
					ram_addr = node_at(lvl_q, idx_q ^ IW'(1));
				end else begin
					fin = 1'b1;
				end
			end
			S_M_ZM: begin
				ram_en = 1'b1;
				ram_we = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLR;
			clr_q      <= '0;
			ram_base_q <= '0;
			done_q     <= 1'b0;
			pend_s1    <= 1'b0;
			iss_en_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= fin;
			if (cfg_valid)
				ram_base_q <= cfg_data;
			case (state_q)
				S_CLR: clr_q <= clr_q + NAW'(1);
				S_IDLE: begin
					lvl_q     <= tl.lvl;
					tgt_q     <= tl.lvl;
					sh_q      <= sh_d;
					idx_q     <= q[IW-1:0];
					iss_lvl_q <= tl.lvl;
					iss_idx_q <= '0;
					iss_en_q  <= 1'b1;
					pend_s1   <= 1'b0;
				end
				S_SCAN: begin
					pend_s1  <= iss_en_q && !found;
					plvl_s1  <= iss_lvl_q;
					pidx_s1  <= iss_idx_q;
					plast_s1 <= iss_lvl_q == '0;
					if (found) begin
						lvl_q    <= plvl_s1;
						idx_q    <= pidx_s1;
						iss_en_q <= 1'b0;
					end else if (iss_en_q) begin
						if (iss_last) begin
							if (iss_lvl_q == '0)
								iss_en_q <= 1'b0;
							else begin
								iss_lvl_q <= iss_lvl_q - LW'(1);
								iss_idx_q <= '0;
							end
						end else begin
							iss_idx_q <= iss_idx_q + IW'(1);
						end
					end
				end
				S_SPL_R: begin
					lvl_q <= lvl_inc;
					idx_q <= {idx_q[IW-2:0], 1'b0};
				end
				S_M_ZM: begin
					lvl_q <= lvl_q - LW'(1);
					idx_q <= idx_q >> 1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (fin) begin
			rsp_q.block_address <= fin_addr;
			rsp_q.status        <= fin_status;
		end
	end

	assign busy      = state_q != S_IDLE;
	assign done      = done_q;
	assign rsp       = rsp_q;
	assign cfg_ready = 1'b1;

`ifndef SYNTHESIS
	a_accept_answers: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done))
		else $error("accepted transfer neither started nor finished");
	a_err_zero_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status != ST_OK) |-> (rsp.block_address == 32'd0))
		else $error("error result carries a nonzero address");
	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !ram_we)
		else $error("node RAM written while idle");
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(busy) || $past(start)))
		else $error("result strobe without a transfer in flight");
`endif

endmodule

// ===== design/bpa_node_ram.sv =====
// ----------------------------------------------------------------------------
// bpa_node_ram: node flag memory
// Single port synchronous RAM, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module bpa_node_ram
	import bpa_pkg::*;
(
	input  logic           clk,
	input  logic           en,
	input  logic           we,
	input  logic [NAW-1:0] addr,
	input  logic [2:0]     wdata,
	output logic [2:0]     rdata
);

	logic [2:0] mem [NODE_COUNT];
	logic [2:0] rdata_q;

	always_ff @(posedge clk) begin
		if (en) begin
			if (we)
				mem[addr] <= wdata;
			else
				rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for the buddy page allocator
// Drives allocate and free commands with random gaps, keeps its own copy of
// the node tree to predict each response, and compares every response with
// the oldest prediction. The region base is rewritten between phases.
// ----------------------------------------------------------------------------
module tb_top;
	import bpa_pkg::*;

	localparam int NODES = (1 << TREE_LEVELS) - 1;
	localparam int WATCHDOG = 20000;

	class alloc_scoreboard;
		logic [2:0]  tree [NODES];
		logic [31:0] base;
		rsp_t        pending [$];
		int          errors;
		int          mismatches;
		int          done_cnt;

		function void clear();
			foreach (tree[n])
				tree[n] = '0;
			tree[0] = FLAG_VALID;
			base = '0;
			errors = 0;
			mismatches = 0;
			done_cnt = 0;
		endfunction

		function int flat(int lvl, int idx);
			return (1 << lvl) - 1 + idx;
		endfunction

		function int level_of(int pages);
			int lg;
			lg = 0;
			if (pages == 0 || pages > MAX_PAGES)
				return -1;
			while ((1 << lg) < pages)
				lg++;
			if (lg > TREE_LEVELS - 1)
				return -1;
			return TREE_LEVELS - 1 - lg;
		endfunction

		function rsp_t do_alloc(int pages);
			rsp_t r;
			int t;
			int lvl;
			int idx;
			bit found;
			logic [2:0] f;
			longint off;
			r = '0;
			t = level_of(pages);
			found = 0;
			idx = 0;
			if (t < 0) begin
				r.status = ST_BAD_SIZE;
				return r;
			end
			for (lvl = t; lvl >= 0; lvl--) begin
				for (idx = 0; idx < (1 << lvl); idx++) begin
					f = tree[flat(lvl, idx)];
					if (f[0] && !f[1] && !f[2]) begin
						found = 1;
						break;
					end
				end
				if (found)
					break;
			end
			if (!found) begin
				r.status = ST_NO_MEM;
				return r;
			end
			while (lvl < t) begin
				tree[flat(lvl, idx)] |= FLAG_SPLIT | FLAG_VALID;
				tree[flat(lvl + 1, 2 * idx)] |= FLAG_VALID;
				tree[flat(lvl + 1, 2 * idx + 1)] |= FLAG_VALID;
				lvl++;
				idx = idx * 2;
			end
			tree[flat(lvl, idx)] |= FLAG_ALLOC;
			off = longint'(idx) * (longint'(PAGE_BYTES) << (TREE_LEVELS - 1 - lvl));
			r.block_address = base + off[31:0];
			r.status = ST_OK;
			return r;
		endfunction

		function rsp_t do_free(int pages, logic [31:0] addr);
			rsp_t r;
			int t;
			int idx;
			longint q;
			logic [31:0] delta;
			logic [2:0] f;
			logic [2:0] b;
			r = '0;
			t = level_of(pages);
			if (t < 0) begin
				r.status = ST_BAD_SIZE;
				return r;
			end
			delta = addr - base;
			q = longint'(delta) / (longint'(PAGE_BYTES) << (TREE_LEVELS - 1 - t));
			if (q >= (longint'(1) << t)) begin
				r.status = ST_BAD_ADDR;
				return r;
			end
			idx = int'(q);
			f = tree[flat(t, idx)];
			if (f[1] || !f[0]) begin
				r.status = ST_BAD_ADDR;
				return r;
			end
			if (t > 0 && !tree[flat(t, idx ^ 1)][0]) begin
				r.status = ST_BUDDY;
				return r;
			end
			forever begin
				tree[flat(t, idx)] = FLAG_VALID;
				if (t == 0)
					break;
				b = tree[flat(t, idx ^ 1)];
				if (b[1] || b[2])
					break;
				tree[flat(t, idx ^ 1)] = '0;
				tree[flat(t, idx)] = '0;
				idx = idx >> 1;
				t--;
			end
			r.status = ST_OK;
			return r;
		endfunction

		function void note_request(req_t q);
			if (q.func == FUNC_ALLOC)
				pending.push_back(do_alloc(int'(q.page_count)));
			else
				pending.push_back(do_free(int'(q.page_count), q.free_address));
		endfunction

		function void check_response(rsp_t got);
			rsp_t exp_r;
			done_cnt++;
			if (pending.size() == 0) begin
				errors++;
				if (mismatches++ < 10)
					$display("Unexpected response: addr %h status %0d",
						got.block_address, got.status);
				return;
			end
			exp_r = pending.pop_front();
			if (got.block_address !== exp_r.block_address || got.status !== exp_r.status) begin
				errors++;
				if (mismatches++ < 10)
					$display("Mismatch: expected addr %h status %0d, got addr %h status %0d",
						exp_r.block_address, exp_r.status, got.block_address, got.status);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	req_t        req;
	logic        done;
	rsp_t        rsp;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [31:0] cfg_data;

	alloc_scoreboard sb;
	int          idle_cycles;
	logic [31:0] live_addr [$];
	int          live_pages [$];

	buddy_page_allocator u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.req      (req),
		.done     (done),
		.rsp      (rsp),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_response(rsp);
	end

	always @(posedge clk) begin
		if ((start && !busy) || (cfg_valid && cfg_ready) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic send(input func_t f, input int pages, input logic [31:0] addr);
		req_t q;
		rsp_t shadow;
		int gap;
		gap = $urandom_range(0, 8);
		q.func = f;
		q.page_count = pages[PAGE_W-1:0];
		q.free_address = addr;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req <= q;
		do
			@(posedge clk);
		while (busy);
		if (f == FUNC_ALLOC) begin
			sb.note_request(q);
			shadow = sb.pending[$];
			if (shadow.status == ST_OK) begin
				live_addr.push_back(shadow.block_address);
				live_pages.push_back(pages);
			end
		end else begin
			sb.note_request(q);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_base(input logic [31:0] value);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.base = value;
		live_addr.delete();
		live_pages.delete();
	endtask

	task automatic free_random_live();
		int k;
		int pg;
		k = $urandom_range(0, live_addr.size() - 1);
		pg = live_pages[k];
		send(FUNC_FREE, pg, live_addr[k] + ($urandom_range(0, 3) == 0 ?
			$urandom_range(0, pg * PAGE_BYTES - 1) : 0));
		live_addr.delete(k);
		live_pages.delete(k);
	endtask

	task automatic random_phase(input int count);
		int r;
		int pg;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			if (r < 45) begin
				pg = $urandom_range(0, 3) == 0 ? $urandom_range(1, 512) : $urandom_range(1, 16);
				send(FUNC_ALLOC, pg, $urandom());
			end else if (r < 85 && live_addr.size() > 0) begin
				free_random_live();
			end else if (r < 93) begin
				send(func_t'($urandom_range(0, 1)), $urandom_range(0, 1023), $urandom());
			end else begin
				pg = 1 << $urandom_range(0, 9);
				send(FUNC_FREE, pg, sb.base + $urandom_range(0, 600) * PAGE_BYTES);
			end
			if (i == count / 2)
				drain();
		end
	endtask

	initial begin
		sb = new();
		sb.clear();
		idle_cycles = 0;
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		send(FUNC_ALLOC, 0, 32'h0);
		send(FUNC_ALLOC, 513, 32'h0);
		send(FUNC_ALLOC, 1023, 32'hFFFF_FFFF);
		send(FUNC_FREE, 0, 32'h0);
		send(FUNC_FREE, 1, 32'h0);
		send(FUNC_ALLOC, 512, 32'h0);
		send(FUNC_ALLOC, 1, 32'h0);
		send(FUNC_FREE, 512, 32'h0);
		send(FUNC_FREE, 512, 32'h0);
		send(FUNC_ALLOC, 1, 32'h0);
		send(FUNC_ALLOC, 3, 32'h0);
		send(FUNC_ALLOC, 100, 32'h0);
		send(FUNC_FREE, 1, 32'h0000_1FFF);
		send(FUNC_FREE, 4, 32'h0004_0000);
		send(FUNC_FREE, 2, 32'h0100_0000);
		send(FUNC_FREE, 256, 32'h0008_0000);
		send(FUNC_FREE, 2, 32'h0000_0000);
		send(FUNC_FREE, 1, 32'h0000_1000);
		send(FUNC_FREE, 4, 32'h0000_4000);
		send(FUNC_FREE, 128, 32'h0000_0000);
		live_addr.delete();
		live_pages.delete();

		write_base(32'hFFFF_F000);
		send(FUNC_ALLOC, 2, 32'h0);
		send(FUNC_FREE, 2, 32'hFFFF_F000);
		random_phase(190);
		write_base(32'h0000_0000);
		random_phase(180);
		write_base($urandom());
		random_phase(190);
		drain();
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
